// ===== rtl/jas_pkg.sv =====
// Shared types, codes and constants for the joystick Ackermann steering block.
`timescale 1ns / 1ps
package jas_pkg;

  // Input request fields.
  typedef struct packed {
    logic               joy_seen;
    logic [3:0]         buttons;
    logic signed [15:0] left_stick_fwd;
    logic signed [15:0] left_stick_side;
    logic signed [15:0] right_stick_side;
    logic signed [15:0] right_stick_fwd;
    logic signed [15:0] remote_speed;
    logic signed [15:0] remote_turn;
    logic signed [15:0] remote_steer_right;
    logic signed [15:0] remote_steer_left;
  } in_t;

  // Result request fields.
  typedef struct packed {
    logic [1:0]         drive_mode;
    logic signed [15:0] speed_out;
    logic signed [15:0] turn_out;
    logic signed [15:0] steer_right_out;
    logic signed [15:0] steer_left_out;
    logic signed [15:0] fore_tilt;
    logic signed [15:0] rear_tilt;
  } out_t;

  // Drive mode codes.
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_REMOTE = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;

  // Button bit positions.
  localparam int BTN_STOP   = 0;
  localparam int BTN_MANUAL = 1;
  localparam int BTN_REMOTE = 2;
  localparam int BTN_ENABLE = 3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAX_SPEED       = 3'd0;
  localparam logic [2:0] CFG_MAX_TURN_RATE   = 3'd1;
  localparam logic [2:0] CFG_MAX_STEER_ANGLE = 3'd2;
  localparam logic [2:0] CFG_TILT_OFFSET     = 3'd3;
  localparam logic [2:0] CFG_RIGHT_OFFSET    = 3'd4;
  localparam logic [2:0] CFG_LEFT_OFFSET     = 3'd5;
  localparam logic [2:0] CFG_TRACK_WIDTH     = 3'd6;

  // Arithmetic constants.
  localparam logic signed [24:0] PI_Q20     = 25'sd3294199;
  localparam logic signed [15:0] HALFPI_Q13 = 16'sd12868;
  localparam logic signed [51:0] GAIN_Q30   = 52'sd652032874;
  localparam logic signed [32:0] ONE_Q30    = 33'sd1073741824;
  localparam logic signed [51:0] NORM_LIM   = 52'sd1099511627776;
  localparam logic signed [49:0] RAD_LIM    = 50'sd67108864;
  localparam logic signed [15:0] W_MIN      = 16'sd41;
  localparam logic [4:0]         STEP_LAST  = 5'd19;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE, S_START, S_MUL_V, S_MUL_W, S_MUL_RH, S_MUL_RV, S_RAD, S_NORM,
    S_ITER, S_DIR, S_CHECK, S_SC_INIT, S_SC_SAVE, S_MUL_VS, S_MUL_VC,
    S_MUL_H, S_DEN_IN, S_ANG_IN, S_DEN_OUT, S_ANG_OUT, S_RESULT
  } state_t;

  // Datapath commands.
  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_MUL_V, CMD_MUL_W, CMD_MUL_RH, CMD_MUL_RV,
    CMD_VEC_STICK, CMD_NORM, CMD_ITER, CMD_DIR, CMD_D_DIR, CMD_SC_INIT,
    CMD_SC_SAVE, CMD_MUL_VS, CMD_MUL_VC, CMD_MUL_H, CMD_VEC_IN, CMD_ANG_IN,
    CMD_VEC_OUT, CMD_ANG_OUT, CMD_RESULT
  } cmd_t;

  // What the shared CORDIC unit is working on.
  typedef enum logic [1:0] {
    JOB_STICK, JOB_SC, JOB_IN, JOB_OUT
  } job_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic joy;
    logic enable;
    logic manual;
    logic remote;
    logic rad_ok;
    logic norm_done;
    logic iter_last;
    logic dir_zero;
    logic w_big;
    logic den_in_zero;
    logic den_out_zero;
    logic out_free;
  } stat_t;

  // Arctangent table, Q20 radians.
  function automatic logic [19:0] atan_q20(input logic [4:0] i);
    logic [19:0] r;
    case (i)
      5'd0:  r = 20'd823550;
      5'd1:  r = 20'd486170;
      5'd2:  r = 20'd256879;
      5'd3:  r = 20'd130396;
      5'd4:  r = 20'd65451;
      5'd5:  r = 20'd32757;
      5'd6:  r = 20'd16383;
      5'd7:  r = 20'd8192;
      5'd8:  r = 20'd4096;
      5'd9:  r = 20'd2048;
      5'd10: r = 20'd1024;
      5'd11: r = 20'd512;
      5'd12: r = 20'd256;
      5'd13: r = 20'd128;
      5'd14: r = 20'd64;
      5'd15: r = 20'd32;
      5'd16: r = 20'd16;
      5'd17: r = 20'd8;
      5'd18: r = 20'd4;
      5'd19: r = 20'd2;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [51:0] a);
    logic signed [15:0] r;
    if (a > 52'sd32767) begin
      r = 16'sh7fff;
    end else if (a < -52'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = a[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/jas_ctrl.sv =====
// Controller state machine that sequences the steering datapath.
`timescale 1ns / 1ps
module jas_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  jas_pkg::stat_t stat,
  output jas_pkg::cmd_t  cmd,
  output logic           busy
);

  jas_pkg::state_t state, state_next;
  jas_pkg::job_t   job, job_next;

  // State and job registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jas_pkg::S_IDLE;
      job   <= jas_pkg::JOB_STICK;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    job_next   = job;
    case (state)
      jas_pkg::S_IDLE: begin
        if (in_valid) state_next = jas_pkg::S_START;
      end
      jas_pkg::S_START: begin
        if (!stat.joy) begin
          state_next = jas_pkg::S_IDLE;
        end else if (stat.enable && stat.manual) begin
          state_next = jas_pkg::S_MUL_V;
        end else begin
          state_next = jas_pkg::S_CHECK;
        end
      end
      jas_pkg::S_MUL_V:  state_next = jas_pkg::S_MUL_W;
      jas_pkg::S_MUL_W:  state_next = jas_pkg::S_MUL_RH;
      jas_pkg::S_MUL_RH: state_next = jas_pkg::S_MUL_RV;
      jas_pkg::S_MUL_RV: state_next = jas_pkg::S_RAD;
      jas_pkg::S_RAD: begin
        if (stat.rad_ok) begin
          state_next = jas_pkg::S_NORM;
          job_next   = jas_pkg::JOB_STICK;
        end else begin
          state_next = jas_pkg::S_CHECK;
        end
      end
      jas_pkg::S_NORM: begin
        if (stat.norm_done) state_next = jas_pkg::S_ITER;
      end
      jas_pkg::S_ITER: begin
        if (stat.iter_last) begin
          case (job)
            jas_pkg::JOB_STICK: state_next = jas_pkg::S_DIR;
            jas_pkg::JOB_SC:    state_next = jas_pkg::S_SC_SAVE;
            jas_pkg::JOB_IN:    state_next = jas_pkg::S_ANG_IN;
            jas_pkg::JOB_OUT:   state_next = jas_pkg::S_ANG_OUT;
            default:            state_next = jas_pkg::S_IDLE;
          endcase
        end
      end
      jas_pkg::S_DIR: state_next = jas_pkg::S_CHECK;
      jas_pkg::S_CHECK: begin
        if (stat.remote) begin
          state_next = jas_pkg::S_RESULT;
        end else if (stat.w_big) begin
          state_next = jas_pkg::S_SC_INIT;
        end else begin
          state_next = jas_pkg::S_RESULT;
        end
      end
      jas_pkg::S_SC_INIT: begin
        if (stat.dir_zero) begin
          state_next = jas_pkg::S_MUL_VS;
        end else begin
          state_next = jas_pkg::S_ITER;
          job_next   = jas_pkg::JOB_SC;
        end
      end
      jas_pkg::S_SC_SAVE: state_next = jas_pkg::S_MUL_VS;
      jas_pkg::S_MUL_VS:  state_next = jas_pkg::S_MUL_VC;
      jas_pkg::S_MUL_VC:  state_next = jas_pkg::S_MUL_H;
      jas_pkg::S_MUL_H:   state_next = jas_pkg::S_DEN_IN;
      jas_pkg::S_DEN_IN: begin
        if (stat.den_in_zero) begin
          state_next = jas_pkg::S_DEN_OUT;
        end else begin
          state_next = jas_pkg::S_NORM;
          job_next   = jas_pkg::JOB_IN;
        end
      end
      jas_pkg::S_ANG_IN: state_next = jas_pkg::S_DEN_OUT;
      jas_pkg::S_DEN_OUT: begin
        if (stat.den_out_zero) begin
          state_next = jas_pkg::S_RESULT;
        end else begin
          state_next = jas_pkg::S_NORM;
          job_next   = jas_pkg::JOB_OUT;
        end
      end
      jas_pkg::S_ANG_OUT: state_next = jas_pkg::S_RESULT;
      jas_pkg::S_RESULT: begin
        if (stat.out_free) state_next = jas_pkg::S_IDLE;
      end
      default: state_next = jas_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd  = jas_pkg::CMD_NONE;
    busy = 1'b1;
    case (state)
      jas_pkg::S_IDLE: begin
        busy = 1'b0;
        if (in_valid) cmd = jas_pkg::CMD_LOAD;
      end
      jas_pkg::S_START:  cmd = jas_pkg::CMD_NONE;
      jas_pkg::S_MUL_V:  cmd = jas_pkg::CMD_MUL_V;
      jas_pkg::S_MUL_W:  cmd = jas_pkg::CMD_MUL_W;
      jas_pkg::S_MUL_RH: cmd = jas_pkg::CMD_MUL_RH;
      jas_pkg::S_MUL_RV: cmd = jas_pkg::CMD_MUL_RV;
      jas_pkg::S_RAD: begin
        if (stat.rad_ok) cmd = jas_pkg::CMD_VEC_STICK;
      end
      jas_pkg::S_NORM: begin
        if (!stat.norm_done) cmd = jas_pkg::CMD_NORM;
      end
      jas_pkg::S_ITER:    cmd = jas_pkg::CMD_ITER;
      jas_pkg::S_DIR:     cmd = jas_pkg::CMD_DIR;
      jas_pkg::S_CHECK:   cmd = jas_pkg::CMD_D_DIR;
      jas_pkg::S_SC_INIT: cmd = jas_pkg::CMD_SC_INIT;
      jas_pkg::S_SC_SAVE: cmd = jas_pkg::CMD_SC_SAVE;
      jas_pkg::S_MUL_VS:  cmd = jas_pkg::CMD_MUL_VS;
      jas_pkg::S_MUL_VC:  cmd = jas_pkg::CMD_MUL_VC;
      jas_pkg::S_MUL_H:   cmd = jas_pkg::CMD_MUL_H;
      jas_pkg::S_DEN_IN:  cmd = jas_pkg::CMD_VEC_IN;
      jas_pkg::S_ANG_IN:  cmd = jas_pkg::CMD_ANG_IN;
      jas_pkg::S_DEN_OUT: cmd = jas_pkg::CMD_VEC_OUT;
      jas_pkg::S_ANG_OUT: cmd = jas_pkg::CMD_ANG_OUT;
      jas_pkg::S_RESULT: begin
        if (stat.out_free) cmd = jas_pkg::CMD_RESULT;
      end
      default: cmd = jas_pkg::CMD_NONE;
    endcase
  end

endmodule

// ===== rtl/jas_dp.sv =====
// Datapath: configuration, shared multiplier, shared CORDIC unit and result register.
`timescale 1ns / 1ps
module jas_dp (
  input  logic           clk,
  input  logic           rst,
  input  jas_pkg::cmd_t  cmd,
  input  jas_pkg::in_t   in_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           out_stall,
  output jas_pkg::stat_t stat,
  output logic           out_valid,
  output jas_pkg::out_t  out_data
);

  // Configuration registers.
  logic [14:0]        max_speed, max_turn_rate, track_width;
  logic [13:0]        max_steer_angle;
  logic signed [15:0] tilt_offset, right_offset, left_offset;

  // Working registers.
  jas_pkg::in_t       item;
  logic [1:0]         mode;
  logic signed [15:0] v, w, dir, d_in, d_out;
  logic signed [49:0] prod, acc, num, vc;
  logic signed [51:0] x, y;
  logic signed [24:0] z;
  logic [4:0]         cnt;
  logic               rot;
  logic signed [32:0] c, s;

  // Combinational helpers.
  logic [1:0]         mode_new;
  logic signed [16:0] ma, av, aw;
  logic signed [32:0] mb;
  logic signed [49:0] mp;
  logic signed [51:0] xs, ys, den_in, den_out, half, num_w;
  logic signed [24:0] at, pioff, a_dir, t_dir, lim, z_rnd;
  logic               pos;
  logic signed [15:0] outer, inner;
  logic signed [17:0] sr_sum, sl_sum;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed       <= 15'd6144;
      max_turn_rate   <= 15'd12868;
      max_steer_angle <= 14'd2859;
      tilt_offset     <= 16'sd0;
      right_offset    <= 16'sd465;
      left_offset     <= 16'sd0;
      track_width     <= 15'd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        jas_pkg::CFG_MAX_SPEED:       max_speed       <= cfg_data[14:0];
        jas_pkg::CFG_MAX_TURN_RATE:   max_turn_rate   <= cfg_data[14:0];
        jas_pkg::CFG_MAX_STEER_ANGLE: max_steer_angle <= cfg_data[13:0];
        jas_pkg::CFG_TILT_OFFSET:     tilt_offset     <= cfg_data;
        jas_pkg::CFG_RIGHT_OFFSET:    right_offset    <= cfg_data;
        jas_pkg::CFG_LEFT_OFFSET:     left_offset     <= cfg_data;
        jas_pkg::CFG_TRACK_WIDTH:     track_width     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Mode update by button priority: stop, then manual, then remote.
  always_comb begin
    mode_new = mode;
    if (in_data.buttons[jas_pkg::BTN_STOP]) begin
      mode_new = jas_pkg::MODE_STOP;
    end else if (in_data.buttons[jas_pkg::BTN_MANUAL]) begin
      mode_new = jas_pkg::MODE_MANUAL;
    end else if (in_data.buttons[jas_pkg::BTN_REMOTE]) begin
      mode_new = jas_pkg::MODE_REMOTE;
    end
  end

  // Shared multiplier operand selection.
  assign av = v[15] ? -{v[15], v} : {v[15], v};
  assign aw = w[15] ? -{w[15], w} : {w[15], w};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd)
      jas_pkg::CMD_MUL_V: begin
        ma = {item.left_stick_fwd[15], item.left_stick_fwd};
        mb = {18'd0, max_speed};
      end
      jas_pkg::CMD_MUL_W: begin
        ma = {item.left_stick_side[15], item.left_stick_side};
        mb = {18'd0, max_turn_rate};
      end
      jas_pkg::CMD_MUL_RH: begin
        ma = {item.right_stick_side[15], item.right_stick_side};
        mb = {{17{item.right_stick_side[15]}}, item.right_stick_side};
      end
      jas_pkg::CMD_MUL_RV: begin
        ma = {item.right_stick_fwd[15], item.right_stick_fwd};
        mb = {{17{item.right_stick_fwd[15]}}, item.right_stick_fwd};
      end
      jas_pkg::CMD_MUL_VS: begin
        ma = av;
        mb = s;
      end
      jas_pkg::CMD_MUL_VC: begin
        ma = av;
        mb = c;
      end
      jas_pkg::CMD_MUL_H: begin
        ma = aw;
        mb = {18'd0, track_width};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mp = ma * mb;

  // CORDIC step: rotation steers z to zero, vectoring steers y to zero.
  assign xs  = x >>> cnt;
  assign ys  = y >>> cnt;
  assign at  = {5'd0, jas_pkg::atan_q20(cnt)};
  assign pos = rot ? !z[24] : y[51];

  // Stick direction: half the atan2, rounded, then clamped.
  assign pioff = item.right_stick_fwd[15] ?
                 (item.right_stick_side[15] ? -jas_pkg::PI_Q20 : jas_pkg::PI_Q20) :
                 25'sd0;
  assign a_dir = z + pioff;
  assign t_dir = (a_dir + 25'sd128) >>> 8;
  assign lim   = $signed({11'd0, max_steer_angle});
  assign z_rnd = (z + 25'sd64) >>> 7;

  // Ackermann denominators, both in Q42.
  assign half    = {{2{prod[49]}}, prod} <<< 17;
  assign den_in  = {{2{vc[49]}}, vc} - half;
  assign den_out = {{2{vc[49]}}, vc} + half;
  assign num_w   = {{2{num[49]}}, num};

  // Inner and outer wheels swap for a negative turn rate.
  assign outer  = w[15] ? d_in : d_out;
  assign inner  = w[15] ? d_out : d_in;
  assign sr_sum = (mode == jas_pkg::MODE_REMOTE) ?
                  -{{2{item.remote_steer_right[15]}}, item.remote_steer_right}
                  + {{2{right_offset[15]}}, right_offset} :
                  -{{2{outer[15]}}, outer} + {{2{right_offset[15]}}, right_offset};
  assign sl_sum = (mode == jas_pkg::MODE_REMOTE) ?
                  -{{2{item.remote_steer_left[15]}}, item.remote_steer_left}
                  + {{2{left_offset[15]}}, left_offset} :
                  -{{2{inner[15]}}, inner} + {{2{left_offset[15]}}, left_offset};

  // Control registers: mode and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jas_pkg::MODE_MANUAL;
      out_valid <= 1'b0;
    end else begin
      if (cmd == jas_pkg::CMD_LOAD && in_data.joy_seen) mode <= mode_new;
      if (cmd == jas_pkg::CMD_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers driven by commands.
  always_ff @(posedge clk) begin
    case (cmd)
      jas_pkg::CMD_LOAD: begin
        item <= in_data;
        dir  <= 16'sd0;
        if (!in_data.buttons[jas_pkg::BTN_ENABLE] && mode_new == jas_pkg::MODE_REMOTE) begin
          v <= in_data.remote_speed;
          w <= in_data.remote_turn;
        end else begin
          v <= 16'sd0;
          w <= 16'sd0;
        end
      end
      jas_pkg::CMD_MUL_V: prod <= mp;
      jas_pkg::CMD_MUL_W: begin
        v    <= jas_pkg::sat16({{2{prod[49]}}, (prod + 50'sd8192) >>> 14});
        prod <= mp;
      end
      jas_pkg::CMD_MUL_RH: begin
        w    <= jas_pkg::sat16({{2{prod[49]}}, (prod + 50'sd8192) >>> 14});
        prod <= mp;
      end
      jas_pkg::CMD_MUL_RV: begin
        acc  <= prod;
        prod <= mp;
      end
      jas_pkg::CMD_VEC_STICK: begin
        if (item.right_stick_fwd[15]) begin
          x <= -{{36{item.right_stick_fwd[15]}}, item.right_stick_fwd};
          y <= -{{36{item.right_stick_side[15]}}, item.right_stick_side};
        end else begin
          x <= {{36{item.right_stick_fwd[15]}}, item.right_stick_fwd};
          y <= {{36{item.right_stick_side[15]}}, item.right_stick_side};
        end
        z   <= 25'sd0;
        cnt <= 5'd0;
        rot <= 1'b0;
      end
      jas_pkg::CMD_NORM: begin
        x <= x <<< 1;
        y <= y <<< 1;
      end
      jas_pkg::CMD_ITER: begin
        if (pos) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + 5'd1;
      end
      jas_pkg::CMD_DIR: begin
        if (t_dir > lim) begin
          dir <= lim[15:0];
        end else if (t_dir < -lim) begin
          dir <= -lim[15:0];
        end else begin
          dir <= t_dir[15:0];
        end
      end
      jas_pkg::CMD_D_DIR: begin
        d_in  <= dir;
        d_out <= dir;
      end
      jas_pkg::CMD_SC_INIT: begin
        if (dir == 16'sd0) begin
          c <= jas_pkg::ONE_Q30;
          s <= 33'sd0;
        end
        x   <= jas_pkg::GAIN_Q30;
        y   <= 52'sd0;
        z   <= {{2{dir[15]}}, dir, 7'd0};
        cnt <= 5'd0;
        rot <= 1'b1;
      end
      jas_pkg::CMD_SC_SAVE: begin
        c <= x[32:0];
        s <= y[32:0];
      end
      jas_pkg::CMD_MUL_VS: prod <= mp;
      jas_pkg::CMD_MUL_VC: begin
        num  <= prod;
        prod <= mp;
      end
      jas_pkg::CMD_MUL_H: begin
        vc   <= prod;
        prod <= mp;
      end
      jas_pkg::CMD_VEC_IN: begin
        if (den_in == 52'sd0) begin
          if (num > 50'sd0) begin
            d_in <= jas_pkg::HALFPI_Q13;
          end else if (num < 50'sd0) begin
            d_in <= -jas_pkg::HALFPI_Q13;
          end else begin
            d_in <= 16'sd0;
          end
        end
        x   <= den_in[51] ? -den_in : den_in;
        y   <= den_in[51] ? -num_w : num_w;
        z   <= 25'sd0;
        cnt <= 5'd0;
        rot <= 1'b0;
      end
      jas_pkg::CMD_ANG_IN: d_in <= z_rnd[15:0];
      jas_pkg::CMD_VEC_OUT: begin
        if (den_out == 52'sd0) begin
          if (num > 50'sd0) begin
            d_out <= jas_pkg::HALFPI_Q13;
          end else if (num < 50'sd0) begin
            d_out <= -jas_pkg::HALFPI_Q13;
          end else begin
            d_out <= 16'sd0;
          end
        end
        x   <= den_out[51] ? -den_out : den_out;
        y   <= den_out[51] ? -num_w : num_w;
        z   <= 25'sd0;
        cnt <= 5'd0;
        rot <= 1'b0;
      end
      jas_pkg::CMD_ANG_OUT: d_out <= z_rnd[15:0];
      jas_pkg::CMD_RESULT: begin
        out_data.drive_mode      <= mode;
        out_data.speed_out       <= v;
        out_data.turn_out        <= w;
        out_data.steer_right_out <= jas_pkg::sat16({{34{sr_sum[17]}}, sr_sum});
        out_data.steer_left_out  <= jas_pkg::sat16({{34{sl_sum[17]}}, sl_sum});
        out_data.fore_tilt       <= tilt_offset;
        out_data.rear_tilt       <= tilt_offset;
      end
      default: ;
    endcase
  end

  // Status to the controller.
  always_comb begin
    stat.joy          = item.joy_seen;
    stat.enable       = item.buttons[jas_pkg::BTN_ENABLE];
    stat.manual       = (mode == jas_pkg::MODE_MANUAL);
    stat.remote       = (mode == jas_pkg::MODE_REMOTE);
    stat.rad_ok       = (acc + prod) > jas_pkg::RAD_LIM;
    stat.norm_done    = (x >= jas_pkg::NORM_LIM) || (x <= -jas_pkg::NORM_LIM) ||
                        (y >= jas_pkg::NORM_LIM) || (y <= -jas_pkg::NORM_LIM);
    stat.iter_last    = (cnt == jas_pkg::STEP_LAST);
    stat.dir_zero     = (dir == 16'sd0);
    stat.w_big        = (w >= jas_pkg::W_MIN) || (w <= -jas_pkg::W_MIN);
    stat.den_in_zero  = (den_in == 52'sd0);
    stat.den_out_zero = (den_out == 52'sd0);
    stat.out_free     = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/joystick_ackermann_steering_top.sv =====
// Top level of the joystick Ackermann steering block.
`timescale 1ns / 1ps
// Usage: each control tick, present a joystick snapshot and the remote commands
// on in_data with in_valid high; the request is taken on an edge where in_stall
// is low. A request with joy_seen clear gives no result and leaves the mode as
// it is. Every other request gives one result on out_data, held under out_valid
// until an edge where out_stall is low.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// while the block is idle; writes take effect on the next edge.
// Remote mode, stop mode and a released enable skip the arithmetic, while manual
// mode runs the shared multiplier and may add the Ackermann path. The work rests
// on the one shared CORDIC unit: 20 iterations each for the stick angle, the sine
// and cosine, and the two wheel angles, every vectoring pass first taking up to
// 40 one-bit normalizing shifts, with the shared multiplier forming one product
// at a time.
// One request is worked at a time; the next one is taken as soon as the result
// sits in the output register, even while the receiver stalls it.
// Reset puts the block in manual mode, loads the register defaults and clears
// the output valid.
module joystick_ackermann_steering_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  jas_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output jas_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  jas_pkg::cmd_t  cmd;
  jas_pkg::stat_t stat;

  // Sequencer.
  jas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (in_stall)
  );

  // Arithmetic and storage.
  jas_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/jas_checker.sv =====
// Port-level checks for the joystick Ackermann steering block, with its bind.
`timescale 1ns / 1ps
module jas_port_checks (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input jas_pkg::out_t out_data
);

  // Reset leaves the block idle with no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A taken request keeps the input stalled while it is worked.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a request was taken");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Both tilt set-points come from the same offset.
  a_tilt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.fore_tilt == out_data.rear_tilt)
    else $error("tilt set-points differ");

  // The reported mode is a defined one.
  a_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.drive_mode != 2'd3)
    else $error("undefined drive mode");

endmodule

bind joystick_ackermann_steering_top jas_port_checks u_jas_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/jas_checker.sv =====
// Checker for the joystick Ackermann steering block: predicts and compares results.
`timescale 1ns / 1ps
module jas_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  jas_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  jas_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output int            fail_count,
  output int            pending
);

  // Shadow copy of the configuration and the mode.
  longint max_speed, max_turn, max_steer, track_w;
  longint tilt_off, right_off, left_off;
  logic [1:0] mode_q;
  jas_pkg::out_t steer_queue[$];

  // Arctangent step table in Q20.
  function automatic longint atan_step(int i);
    longint tbl[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  // Arithmetic shift right rounding toward minus infinity.
  function automatic longint shr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Vectoring CORDIC, angle of (x, y) in Q20 for x >= 0.
  function automatic longint vec_q20(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    while (absv(x) < (64'sd1 <<< 40) && absv(y) < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 20; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  // Wheel angle in Q3.13 from numerator and denominator.
  function automatic longint wheel_angle(longint num, longint den);
    if (den == 0) begin
      if (num > 0) return 12868;
      if (num < 0) return -12868;
      return 0;
    end
    if (den < 0) begin
      num = -num; den = -den;
    end
    return shr(vec_q20(den, num) + 64, 7);
  endfunction

  // Full tick prediction; updates the mode.
  function automatic jas_pkg::out_t predict_tick(jas_pkg::in_t r);
    jas_pkg::out_t o;
    longint v, w, dir, d_in, d_out, t, c, s, x, y, z, dx, dy, num, half, a, rh, rv;
    v = 0; w = 0; dir = 0;
    if (r.buttons[jas_pkg::BTN_STOP]) mode_q = jas_pkg::MODE_STOP;
    else if (r.buttons[jas_pkg::BTN_MANUAL]) mode_q = jas_pkg::MODE_MANUAL;
    else if (r.buttons[jas_pkg::BTN_REMOTE]) mode_q = jas_pkg::MODE_REMOTE;
    rh = r.right_stick_side;
    rv = r.right_stick_fwd;
    if (r.buttons[jas_pkg::BTN_ENABLE]) begin
      if (mode_q == jas_pkg::MODE_MANUAL) begin
        v = clip16(shr(longint'(r.left_stick_fwd) * max_speed + 8192, 14));
        w = clip16(shr(longint'(r.left_stick_side) * max_turn + 8192, 14));
        if (rh * rh + rv * rv > (64'sd1 <<< 26)) begin
          if (rv < 0) a = vec_q20(-rv, -rh) + (rh >= 0 ? 3294199 : -3294199);
          else a = vec_q20(rv, rh);
          dir = shr(a + 128, 8);
        end
      end
    end else if (mode_q == jas_pkg::MODE_REMOTE) begin
      v = r.remote_speed;
      w = r.remote_turn;
    end
    if (dir > max_steer) dir = max_steer;
    if (dir < -max_steer) dir = -max_steer;
    if (absv(w) >= 41) begin
      if (dir == 0) begin
        c = 64'sd1 <<< 30; s = 0;
      end else begin
        x = 652032874; y = 0; z = dir * 128;
        for (int i = 0; i < 20; i++) begin
          dx = shr(y, i);
          dy = shr(x, i);
          if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
          end else begin
            x += dx; y -= dy; z += atan_step(i);
          end
        end
        c = x; s = y;
      end
      num = absv(v) * s;
      half = absv(w) * track_w * 131072;
      d_in = wheel_angle(num, absv(v) * c - half);
      d_out = wheel_angle(num, absv(v) * c + half);
      if (w < 0) begin
        t = d_in; d_in = d_out; d_out = t;
      end
    end else begin
      d_in = dir; d_out = dir;
    end
    o.drive_mode = mode_q;
    o.speed_out = 16'(clip16(v));
    o.turn_out = 16'(clip16(w));
    if (mode_q == jas_pkg::MODE_REMOTE) begin
      o.steer_right_out = 16'(clip16(-longint'(r.remote_steer_right) + right_off));
      o.steer_left_out = 16'(clip16(-longint'(r.remote_steer_left) + left_off));
    end else begin
      o.steer_right_out = 16'(clip16(-d_out + right_off));
      o.steer_left_out = 16'(clip16(-d_in + left_off));
    end
    o.fore_tilt = 16'(tilt_off);
    o.rear_tilt = 16'(tilt_off);
    return o;
  endfunction

  // Watch configuration writes, requests and results.
  always @(posedge clk) begin
    jas_pkg::out_t exp_o;
    if (rst) begin
      max_speed <= 6144; max_turn <= 12868; max_steer <= 2859;
      tilt_off <= 0; right_off <= 465; left_off <= 0; track_w <= 2048;
      mode_q = jas_pkg::MODE_MANUAL;
      fail_count <= 0;
      pending <= 0;
      steer_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jas_pkg::CFG_MAX_SPEED:       max_speed <= cfg_data[14:0];
          jas_pkg::CFG_MAX_TURN_RATE:   max_turn <= cfg_data[14:0];
          jas_pkg::CFG_MAX_STEER_ANGLE: max_steer <= cfg_data[13:0];
          jas_pkg::CFG_TILT_OFFSET:     tilt_off <= longint'(signed'(cfg_data));
          jas_pkg::CFG_RIGHT_OFFSET:    right_off <= longint'(signed'(cfg_data));
          jas_pkg::CFG_LEFT_OFFSET:     left_off <= longint'(signed'(cfg_data));
          jas_pkg::CFG_TRACK_WIDTH:     track_w <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall && in_data.joy_seen) begin
        steer_queue.push_back(predict_tick(in_data));
      end
      if (out_valid && !out_stall) begin
        if (steer_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_o = steer_queue.pop_front();
          if (exp_o !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_o, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= steer_queue.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the joystick Ackermann steering block: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  jas_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  jas_pkg::out_t out_data;
  logic cfg_we = 0;
  logic [2:0] cfg_index = jas_pkg::CFG_MAX_SPEED;
  logic [15:0] cfg_data = '0;
  int fail_count, pending;
  int in_idle_pct = 34, out_idle_pct = 34;
  int hold_cycles = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  longint cycles = 0;

  always #5 clk = ~clk;

  joystick_ackermann_steering_top u_dut (.*);

  jas_checker u_chk (.*);

  // Generous watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stall: random, plus one long hold-off once it is asked for.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1;
      hold_cycles <= 2000;
      hold_done <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic logic signed [15:0] stick_val();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      3: return 16'sd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic jas_pkg::in_t random_request();
    jas_pkg::in_t r;
    logic [159:0] fill;
    fill = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = fill[$bits(jas_pkg::in_t)-1:0];
    r.joy_seen = ($urandom_range(9) != 0);
    r.left_stick_fwd = stick_val();
    r.left_stick_side = stick_val();
    r.right_stick_side = stick_val();
    r.right_stick_fwd = stick_val();
    if ($urandom_range(3) != 0) begin
      r.buttons = $urandom_range(1) ? 4'b1010 : 4'b1000;
    end
    return r;
  endfunction

  // Offer one request and wait until it is taken.
  task automatic send_request(jas_pkg::in_t r, bit no_gaps);
    while (!no_gaps && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // One register write; the caller drops the enable after the last one.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] ms, logic [15:0] mt, logic [15:0] sa,
                          logic [15:0] tl, logic [15:0] ro, logic [15:0] lo,
                          logic [15:0] tw);
    write_reg(jas_pkg::CFG_MAX_SPEED, ms);
    write_reg(jas_pkg::CFG_MAX_TURN_RATE, mt);
    write_reg(jas_pkg::CFG_MAX_STEER_ANGLE, sa);
    write_reg(jas_pkg::CFG_TILT_OFFSET, tl);
    write_reg(jas_pkg::CFG_RIGHT_OFFSET, ro);
    write_reg(jas_pkg::CFG_LEFT_OFFSET, lo);
    write_reg(jas_pkg::CFG_TRACK_WIDTH, tw);
    cfg_we <= 0;
  endtask

  initial begin
    jas_pkg::in_t r;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed requests: modes, extremes, zero direction, enable off.
    r = '0; r.joy_seen = 1;
    r.buttons = 4'b1010; r.left_stick_fwd = 16'sd16384; r.left_stick_side = 16'sd16384;
    r.right_stick_side = 16'sd16384; r.right_stick_fwd = 16'sd0;
    send_request(r, 0);
    r.left_stick_side = -16'sd16384; r.right_stick_side = -16'sd16384;
    send_request(r, 0);
    r.right_stick_side = 16'sd0; r.right_stick_fwd = -16'sd16384;
    send_request(r, 0);
    r.left_stick_side = 16'sd0; r.left_stick_fwd = -16'sd16384;
    send_request(r, 0);
    r.left_stick_side = 16'sd20; r.right_stick_side = 16'sd100; r.right_stick_fwd = 16'sd100;
    send_request(r, 0);
    r.left_stick_fwd = 16'sd0; r.left_stick_side = 16'sd16384;
    send_request(r, 0);
    r.left_stick_fwd = 16'sh7fff; r.left_stick_side = 16'sh8000;
    r.right_stick_side = 16'sh7fff; r.right_stick_fwd = 16'sh8000;
    send_request(r, 0);
    r.buttons = 4'b0000; r.joy_seen = 0;
    send_request(r, 0);
    r.joy_seen = 1; r.buttons = 4'b0100; r.remote_speed = 16'sh7fff;
    r.remote_turn = 16'sh8000; r.remote_steer_right = 16'sh8000;
    r.remote_steer_left = 16'sh7fff;
    send_request(r, 0);
    r.remote_turn = 16'sd40; r.remote_speed = -16'sd5;
    send_request(r, 0);
    r.buttons = 4'b1000;
    send_request(r, 0);
    r.buttons = 4'b0001;
    send_request(r, 0);
    r.buttons = 4'b1111;
    send_request(r, 0);
    r.buttons = 4'b1010; r.left_stick_fwd = 16'sd1000; r.left_stick_side = 16'sd16384;
    r.right_stick_side = 16'sd16384; r.right_stick_fwd = 16'sd16384;
    send_request(r, 0);
    drain();

    // Extreme, zero, mid, random and default settings, each followed by random requests.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_regs(16'h7fff, 16'h7fff, 16'h3fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        1: set_regs(16'h0, 16'h0, 16'h0, 16'h8000, 16'h7fff, 16'h8000, 16'h0);
        2: set_regs(16'd6144, 16'd12868, 16'd12868, 16'd0, 16'd465, 16'd0, 16'd1);
        3: set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
        default: set_regs(16'd6144, 16'd12868, 16'd2859, 16'd0, 16'd465, 16'd0, 16'd2048);
      endcase
      if (phase == 2) in_idle_pct = 0;
      else in_idle_pct = 34;
      if (phase == 2) out_idle_pct = 0;
      else out_idle_pct = 34;
      if (phase == 4) hold_req = 1;
      for (int k = 0; k < 240; k++) send_request(random_request(), 0);
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
